// ----- rtl/rk4i_pkg.sv -----
package rk4i_pkg;

  // word format
  localparam int WordBits = 32;
  localparam int FracBits = 24;
  localparam int StepBits = 25;
  localparam int CfgIdxBits = 2;

  // operand and product widths of the shared unit
  localparam int OpBits = WordBits + 1;
  localparam int ProdBits = 2 * OpBits;

  // reciprocal of six for the final divide, scaled by 2**RecipShift and rounded up
  localparam int RecipShift = WordBits + 1;
  localparam logic [OpBits+1:0] RecipNum = (OpBits+2)'(1) << RecipShift;
  localparam logic [OpBits-1:0] Recip = OpBits'((RecipNum + (OpBits+2)'(5)) / (OpBits+2)'(6));

  typedef logic signed [WordBits-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

  // register reset values
  localparam logic [StepBits-1:0] StepReset = StepBits'(16777);
  localparam word_t GainAReset = WordBits'(2516582);
  localparam word_t OffsetBReset = WordBits'(3355443);
  localparam word_t ShiftCReset = WordBits'(134217728);

  // sequencer step counts
  localparam logic [3:0] InitLast = 4'd2;
  localparam logic [3:0] BodyLast = 4'd14;
  localparam logic [3:0] TailLast = 4'd5;
  localparam logic [3:0] TailLastEnd = 4'd2;
  localparam logic [3:0] FinalLast = 4'd5;
  localparam logic [1:0] LastStage = 2'd3;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_STEP     = 2'd0,
    CFG_GAIN_A   = 2'd1,
    CFG_OFFSET_B = 2'd2,
    CFG_SHIFT_C  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [StepBits-1:0] step;
    word_t               gain_a;
    word_t               offset_b;
    word_t               shift_c;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_HADD,
    OP_DADD,
    OP_MUL,
    OP_FIX,
    OP_RCP,
    OP_QADD
  } op_e;

  typedef enum logic [4:0] {
    R_ZERO,
    R_H,
    R_A,
    R_B,
    R_C,
    R_PX,
    R_PY,
    R_PZ,
    R_EX,
    R_EY,
    R_EZ,
    R_KX,
    R_KY,
    R_KZ,
    R_SX,
    R_SY,
    R_SZ,
    R_T
  } reg_e;

  typedef struct packed {
    op_e  op;
    reg_e src_a;
    reg_e src_b;
    reg_e dst;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic clr;
  } ctl_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_INIT  = 6'b000010,
    ST_BODY  = 6'b000100,
    ST_TAIL  = 6'b001000,
    ST_FINAL = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  // clamp a one-bit-grown sum to the word range
  function automatic word_t sat_op(logic signed [OpBits-1:0] v);
    word_t r;
    if (v[OpBits-1] != v[OpBits-2]) begin
      r = v[OpBits-1] ? WordMin : WordMax;
    end else begin
      r = v[WordBits-1:0];
    end
    return r;
  endfunction

  // clamp a shifted product to the word range
  function automatic word_t sat_prod(logic signed [ProdBits-1:0] v);
    word_t r;
    if ((&v[ProdBits-1:WordBits-1]) || !(|v[ProdBits-1:WordBits-1])) begin
      r = v[WordBits-1:0];
    end else begin
      r = v[ProdBits-1] ? WordMin : WordMax;
    end
    return r;
  endfunction

  function automatic reg_e axis_reg(reg_e rx, reg_e ry, reg_e rz, logic [1:0] axis);
    reg_e r;
    case (axis)
      2'd0:    r = rx;
      2'd1:    r = ry;
      default: r = rz;
    endcase
    return r;
  endfunction

  // copy the state into the evaluation point
  function automatic uop_t init_uop(logic [3:0] step);
    uop_t u;
    u = '{OP_ADD, axis_reg(R_PX, R_PY, R_PZ, step[1:0]), R_ZERO,
          axis_reg(R_EX, R_EY, R_EZ, step[1:0])};
    return u;
  endfunction

  // one slope evaluation: k = h * f(e)
  function automatic uop_t body_uop(logic [3:0] step);
    uop_t u;
    case (step)
      4'd0:    u = '{OP_SUB, R_ZERO, R_EY, R_T};
      4'd1:    u = '{OP_SUB, R_T, R_EZ, R_T};
      4'd2:    u = '{OP_MUL, R_H, R_T, R_ZERO};
      4'd3:    u = '{OP_FIX, R_ZERO, R_ZERO, R_KX};
      4'd4:    u = '{OP_MUL, R_A, R_EY, R_ZERO};
      4'd5:    u = '{OP_FIX, R_ZERO, R_ZERO, R_T};
      4'd6:    u = '{OP_ADD, R_EX, R_T, R_T};
      4'd7:    u = '{OP_MUL, R_H, R_T, R_ZERO};
      4'd8:    u = '{OP_FIX, R_ZERO, R_ZERO, R_KY};
      4'd9:    u = '{OP_SUB, R_EX, R_C, R_T};
      4'd10:   u = '{OP_MUL, R_EZ, R_T, R_ZERO};
      4'd11:   u = '{OP_FIX, R_ZERO, R_ZERO, R_T};
      4'd12:   u = '{OP_ADD, R_B, R_T, R_T};
      4'd13:   u = '{OP_MUL, R_H, R_T, R_ZERO};
      4'd14:   u = '{OP_FIX, R_ZERO, R_ZERO, R_KZ};
      default: u = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO};
    endcase
    return u;
  endfunction

  // fold k into the weighted sum, then, before the last stage, set up the next evaluation point
  function automatic uop_t tail_uop(logic [1:0] stage, logic [3:0] step);
    uop_t u;
    logic [1:0] ax;
    reg_e rs;
    reg_e rk;
    reg_e re;
    reg_e rp;
    ax = (step < 4'd3) ? step[1:0] : 2'(step - 4'd3);
    rs = axis_reg(R_SX, R_SY, R_SZ, ax);
    rk = axis_reg(R_KX, R_KY, R_KZ, ax);
    re = axis_reg(R_EX, R_EY, R_EZ, ax);
    rp = axis_reg(R_PX, R_PY, R_PZ, ax);
    u = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO};
    if (step < 4'd3) begin
      case (stage)
        2'd0:      u = '{OP_ADD, R_ZERO, rk, rs};
        LastStage: u = '{OP_ADD, rs, rk, rs};
        default:   u = '{OP_DADD, rs, rk, rs};
      endcase
    end else if (step <= TailLast) begin
      if (stage == 2'd2) begin
        u = '{OP_ADD, rp, rk, re};
      end else begin
        u = '{OP_HADD, rp, rk, re};
      end
    end
    return u;
  endfunction

  // state += sum / 6, two micro-ops per axis
  function automatic uop_t final_uop(logic [3:0] step);
    uop_t u;
    reg_e rs;
    reg_e rp;
    rs = axis_reg(R_SX, R_SY, R_SZ, step[2:1]);
    rp = axis_reg(R_PX, R_PY, R_PZ, step[2:1]);
    if (!step[0]) begin
      u = '{OP_RCP, rs, R_ZERO, R_ZERO};
    end else begin
      u = '{OP_QADD, rp, R_ZERO, rp};
    end
    return u;
  endfunction

endpackage

// ----- rtl/rk4i_seq.sv -----
module rk4i_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            restart_i,
  input  logic            out_free_i,
  output logic            out_load_o,
  output rk4i_pkg::ctl_t  ctl_o
);
  import rk4i_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] stage_q, stage_d;
  logic [3:0] step_q, step_d;

  // phase sequencing
  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    step_d  = step_q + 4'd1;
    ctl_o.clr = 1'b0;
    ctl_o.uop = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO};
    unique case (state_q)
      ST_IDLE: begin
        step_d  = '0;
        stage_d = '0;
        if (in_valid_i) begin
          ctl_o.clr = restart_i;
          state_d   = restart_i ? ST_DONE : ST_INIT;
        end
      end
      ST_INIT: begin
        ctl_o.uop = init_uop(step_q);
        if (step_q == InitLast) begin
          state_d = ST_BODY;
          step_d  = '0;
        end
      end
      ST_BODY: begin
        ctl_o.uop = body_uop(step_q);
        if (step_q == BodyLast) begin
          state_d = ST_TAIL;
          step_d  = '0;
        end
      end
      ST_TAIL: begin
        ctl_o.uop = tail_uop(stage_q, step_q);
        if (stage_q == LastStage && step_q == TailLastEnd) begin
          state_d = ST_FINAL;
          step_d  = '0;
        end else if (stage_q != LastStage && step_q == TailLast) begin
          state_d = ST_BODY;
          stage_d = stage_q + 2'd1;
          step_d  = '0;
        end
      end
      ST_FINAL: begin
        ctl_o.uop = final_uop(step_q);
        if (step_q == FinalLast) begin
          state_d = ST_DONE;
          step_d  = '0;
        end
      end
      ST_DONE: begin
        step_d = '0;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load_o = (state_q == ST_DONE) && out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- rtl/rk4i_dp.sv -----
module rk4i_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rk4i_pkg::cfg_t  cfg_i,
  input  rk4i_pkg::ctl_t  ctl_i,
  output rk4i_pkg::word_t pos_x_o,
  output rk4i_pkg::word_t pos_y_o,
  output rk4i_pkg::word_t pos_z_o
);
  import rk4i_pkg::*;

  word_t px_q, py_q, pz_q;
  word_t ex_q, ey_q, ez_q;
  word_t kx_q, ky_q, kz_q;
  word_t sx_q, sy_q, sz_q;
  word_t t_q;
  logic signed [ProdBits-1:0] p_q, p_d;
  logic neg_q;

  word_t a_val, b_val, dbl, q_word, wr_val;
  logic signed [OpBits-1:0] a_ext, b_ext, mag, q_ext;
  logic signed [OpBits-1:0] mul_a, mul_b;
  logic signed [ProdBits-1:0] prod;
  logic wr_en;

  // operand a select
  always_comb begin
    case (ctl_i.uop.src_a)
      R_H:     a_val = word_t'({{(WordBits-StepBits){1'b0}}, cfg_i.step});
      R_A:     a_val = cfg_i.gain_a;
      R_B:     a_val = cfg_i.offset_b;
      R_C:     a_val = cfg_i.shift_c;
      R_PX:    a_val = px_q;
      R_PY:    a_val = py_q;
      R_PZ:    a_val = pz_q;
      R_EX:    a_val = ex_q;
      R_EY:    a_val = ey_q;
      R_EZ:    a_val = ez_q;
      R_KX:    a_val = kx_q;
      R_KY:    a_val = ky_q;
      R_KZ:    a_val = kz_q;
      R_SX:    a_val = sx_q;
      R_SY:    a_val = sy_q;
      R_SZ:    a_val = sz_q;
      R_T:     a_val = t_q;
      default: a_val = '0;
    endcase
  end

  // operand b select
  always_comb begin
    case (ctl_i.uop.src_b)
      R_H:     b_val = word_t'({{(WordBits-StepBits){1'b0}}, cfg_i.step});
      R_A:     b_val = cfg_i.gain_a;
      R_B:     b_val = cfg_i.offset_b;
      R_C:     b_val = cfg_i.shift_c;
      R_PX:    b_val = px_q;
      R_PY:    b_val = py_q;
      R_PZ:    b_val = pz_q;
      R_EX:    b_val = ex_q;
      R_EY:    b_val = ey_q;
      R_EZ:    b_val = ez_q;
      R_KX:    b_val = kx_q;
      R_KY:    b_val = ky_q;
      R_KZ:    b_val = kz_q;
      R_SX:    b_val = sx_q;
      R_SY:    b_val = sy_q;
      R_SZ:    b_val = sz_q;
      R_T:     b_val = t_q;
      default: b_val = '0;
    endcase
  end

  assign a_ext  = {a_val[WordBits-1], a_val};
  assign b_ext  = {b_val[WordBits-1], b_val};
  assign mag    = a_val[WordBits-1] ? -a_ext : a_ext;
  assign dbl    = sat_op(b_ext + b_ext);
  // quotient of the reciprocal multiply, sign restored
  assign q_word = p_q[RecipShift +: WordBits];
  assign q_ext  = neg_q ? -{1'b0, q_word} : {1'b0, q_word};

  // one multiplier: reciprocal scaling or operand product
  assign mul_a = (ctl_i.uop.op == OP_RCP) ? mag : a_ext;
  assign mul_b = (ctl_i.uop.op == OP_RCP) ? $signed(Recip) : b_ext;
  assign prod  = mul_a * mul_b;

  // shared unit: saturating adder, multiplier into the product register
  always_comb begin
    wr_en  = 1'b0;
    wr_val = a_val;
    p_d    = p_q;
    case (ctl_i.uop.op)
      OP_ADD: begin
        wr_en  = 1'b1;
        wr_val = sat_op(a_ext + b_ext);
      end
      OP_SUB: begin
        wr_en  = 1'b1;
        wr_val = sat_op(a_ext - b_ext);
      end
      OP_HADD: begin
        wr_en  = 1'b1;
        wr_val = sat_op(a_ext + (b_ext >>> 1));
      end
      OP_DADD: begin
        wr_en  = 1'b1;
        wr_val = sat_op(a_ext + {dbl[WordBits-1], dbl});
      end
      OP_MUL: begin
        p_d = prod;
      end
      OP_FIX: begin
        wr_en  = 1'b1;
        wr_val = sat_prod(p_q >>> FracBits);
      end
      OP_RCP: begin
        p_d = prod;
      end
      OP_QADD: begin
        wr_en  = 1'b1;
        wr_val = sat_op(a_ext + q_ext);
      end
      default: ;
    endcase
  end

  // state registers, cleared by reset and by a restart beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else if (ctl_i.clr) begin
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else if (wr_en) begin
      unique case (ctl_i.uop.dst)
        R_PX:    px_q <= wr_val;
        R_PY:    py_q <= wr_val;
        R_PZ:    pz_q <= wr_val;
        default: ;
      endcase
    end
  end

  // scratch registers and product
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (ctl_i.uop.op == OP_RCP) begin
      neg_q <= a_val[WordBits-1];
    end
    if (wr_en) begin
      unique case (ctl_i.uop.dst)
        R_EX:    ex_q <= wr_val;
        R_EY:    ey_q <= wr_val;
        R_EZ:    ez_q <= wr_val;
        R_KX:    kx_q <= wr_val;
        R_KY:    ky_q <= wr_val;
        R_KZ:    kz_q <= wr_val;
        R_SX:    sx_q <= wr_val;
        R_SY:    sy_q <= wr_val;
        R_SZ:    sz_q <= wr_val;
        R_T:     t_q  <= wr_val;
        default: ;
      endcase
    end
  end

  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign pos_z_o = pz_q;

endmodule

// ----- rtl/rossler_rk4_integrator.sv -----
// channel   direction  beat contents
// cfg       in         cfg_index_i (register), cfg_data_i (value), always ready
// in        in         restart_i
// out       out        x_out_o, y_out_o, z_out_o
//
// a step beat runs from acceptance to a result in the output register in phases:
// copy, four slope evaluations, accumulate, divide-and-update, hand-off, through one
// 33x33 multiplier and one saturating adder; a new beat is taken only after the hand-off.
// a restart beat clears x, y, z and goes straight to the hand-off step to load a zero result.
// reset leaves x, y, z at zero and the registers at their defaults.
// a stalled output holds the sequencer at its hand-off step.
module rossler_rk4_integrator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rk4i_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [rk4i_pkg::WordBits-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rk4i_pkg::WordBits-1:0] x_out_o,
  output logic signed [rk4i_pkg::WordBits-1:0] y_out_o,
  output logic signed [rk4i_pkg::WordBits-1:0] z_out_o
);
  import rk4i_pkg::*;

  cfg_t  cfg_q;
  ctl_t  ctl;
  word_t pos_x, pos_y, pos_z;
  word_t x_q, y_q, z_q;
  logic  out_valid_q;
  logic  out_free;
  logic  out_load;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step     <= StepReset;
      cfg_q.gain_a   <= GainAReset;
      cfg_q.offset_b <= OffsetBReset;
      cfg_q.shift_c  <= ShiftCReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEP:     cfg_q.step     <= cfg_data_i[StepBits-1:0];
        CFG_GAIN_A:   cfg_q.gain_a   <= cfg_data_i;
        CFG_OFFSET_B: cfg_q.offset_b <= cfg_data_i;
        CFG_SHIFT_C:  cfg_q.shift_c  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rk4i_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .ctl_o      (ctl)
  );

  rk4i_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctl_i   (ctl),
    .pos_x_o (pos_x),
    .pos_y_o (pos_y),
    .pos_z_o (pos_z)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      x_q <= pos_x;
      y_q <= pos_y;
      z_q <= pos_z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_q;
  assign y_out_o     = y_q;
  assign z_out_o     = z_q;

  // the block is busy right after any accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a beat is in flight");

  // a result appears only from the hand-off step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a beat in flight");

  // a restart into an empty output gives a zero result through the hand-off step and the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && restart_i && !out_valid_o) |=>
      ##1 (out_valid_o && x_out_o == '0 && y_out_o == '0 && z_out_o == '0))
    else $error("restart did not clear the state");

endmodule
